// ----- src/lru_page_replacement_macros.svh -----
// Assertion macros used by the checker of the page replacement block.
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define LRUPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lru_page_replacement check failed");

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define LRUPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lru_page_replacement check failed");

`endif

// ----- src/lrupr_pkg.sv -----
// Shared types and constants of the page replacement block.
`default_nettype none
package lrupr_pkg;

    localparam int CFG_W      = 4;
    localparam int OUT_SLOT_W = 3;
    localparam int OUT_PAGE_W = 8;
    localparam int FAULT_W    = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd3;
    localparam logic [FAULT_W-1:0] FAULT_MAX = 16'hFFFF;

    // Control handed from the top level to one cell.
    typedef struct packed {
        logic clear;  // return to the reset entry
        logic take;   // load the entry offered at the data input
    } t_cell_ctrl;

    // Status one cell reports for the current reference.
    typedef struct packed {
        logic active; // slot number lies below the active frame count
        logic hit;    // active, occupied and holding the referenced page
        logic empty;  // active and not occupied
    } t_cell_stat;

endpackage
`default_nettype wire

// ----- src/lrupr_cell.sv -----
// One recency stack position: slot number, occupancy and resident page.
`default_nettype none
module lrupr_cell #(
    parameter int SLOT_W = 3,
    parameter int PAGE_W = 8,
    parameter int INDEX  = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire lrupr_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [SLOT_W-1:0]     i_d_slot,
    input  wire logic                  i_d_valid,
    input  wire logic [PAGE_W-1:0]     i_d_page,
    input  wire logic [PAGE_W-1:0]     i_page,
    input  wire logic [SLOT_W:0]       i_active_cnt,
    output logic [SLOT_W-1:0]          o_slot,
    output logic                       o_valid,
    output logic [PAGE_W-1:0]          o_page,
    output lrupr_pkg::t_cell_stat      o_stat
);
    import lrupr_pkg::*;

    logic [SLOT_W-1:0] r_slot;
    logic              r_valid;
    logic [PAGE_W-1:0] r_page;
    logic              active;

    // The slot number and occupancy are control state; the page is payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_slot  <= SLOT_W'(INDEX);
            r_valid <= 1'b0;
        end else if (i_ctrl.take) begin
            r_slot  <= i_d_slot;
            r_valid <= i_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.take) begin
            r_page <= i_d_page;
        end
    end

    assign active       = {1'b0, r_slot} < i_active_cnt;
    assign o_stat.active = active;
    assign o_stat.hit    = active && r_valid && (r_page == i_page);
    assign o_stat.empty  = active && !r_valid;
    assign o_slot        = r_slot;
    assign o_valid       = r_valid;
    assign o_page        = r_page;

endmodule
`default_nettype wire

// ----- src/lru_page_replacement.sv -----
// Top level of the least-recently-used page replacement block.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  input    | i_valid / o_stall    | i_page, i_last_reference
//  result   | o_valid / i_stall    | o_hit, o_frame_slot, o_evicted_valid,
//           |                      | o_evicted_page, o_fault_count
//  config   | i_cfg_we             | i_cfg_data (frames_in_use)
//
// Every reference is resolved in the cycle it is accepted and its result is
// registered, so one reference per cycle is taken while the result side keeps up.
// Within that cycle the work is the lookup across the row of cells, the
// choice of hit, empty or victim slot, and the one-step shift of the stack.
// Reset is synchronous and active low; it restores the frame count to 3 and
// the stack to slot order with all frames empty. A stalled result holds the
// output register and raises o_stall, which holds off the next reference.
`default_nettype none
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 8
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [lrupr_pkg::OUT_PAGE_W-1:0]  i_page,
    input  wire logic                              i_last_reference,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_hit,
    output logic [lrupr_pkg::OUT_SLOT_W-1:0]       o_frame_slot,
    output logic                                   o_evicted_valid,
    output logic [lrupr_pkg::OUT_PAGE_W-1:0]       o_evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]          o_fault_count
);
    import lrupr_pkg::*;

    // Slot numbers need enough bits for FRAMES slots; the active count one
    // more so that it can hold FRAMES itself. Pages beyond the port width
    // are never seen, so the stored page is the narrower of the two.
    localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W = (PAGE_BITS < OUT_PAGE_W) ? PAGE_BITS : OUT_PAGE_W;

    logic [CFG_W-1:0]   r_frames_cfg;
    logic [SLOT_W:0]    active_cnt;
    logic [CFG_W:0]     cfg_ext;
    logic               in_accept;
    logic [PAGE_W-1:0]  page_in;

    // Row of cells, position 0 is the most recently used.
    t_cell_ctrl         cell_ctrl  [FRAMES];
    t_cell_stat         cell_stat  [FRAMES];
    logic [SLOT_W-1:0]  cell_slot  [FRAMES];
    logic               cell_valid [FRAMES];
    logic [PAGE_W-1:0]  cell_page  [FRAMES];
    logic [SLOT_W-1:0]  d_slot     [FRAMES];
    logic               d_valid    [FRAMES];
    logic [PAGE_W-1:0]  d_page     [FRAMES];

    logic [FRAMES-1:0]  hit_vec;
    logic [FRAMES-1:0]  empty_vec;
    logic [FRAMES-1:0]  take_vec;
    logic               any_hit;
    logic               any_empty;
    logic [SLOT_W-1:0]  hit_slot;
    logic [SLOT_W-1:0]  empty_slot;
    logic [SLOT_W-1:0]  victim_slot;
    logic [PAGE_W-1:0]  victim_page;
    logic [SLOT_W-1:0]  chosen_slot;

    logic [FAULT_W-1:0] r_fault;
    logic [FAULT_W-1:0] n_fault;

    logic                  r_out_valid;
    logic                  r_hit;
    logic [OUT_SLOT_W-1:0] r_slot;
    logic                  r_ev_valid;
    logic [OUT_PAGE_W-1:0] r_ev_page;
    logic [FAULT_W-1:0]    r_fault_out;

    // A new reference is held off only while a finished result waits.
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign page_in   = i_page[PAGE_W-1:0];

    // Frame count register; a last reference leaves it untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_frames_cfg <= i_cfg_data;
        end
    end

    // A count of zero acts as one, and a count above FRAMES as FRAMES.
    always_comb begin
        cfg_ext = {1'b0, r_frames_cfg};
        priority if (cfg_ext == '0) begin
            active_cnt = (SLOT_W+1)'(1);
        end else if (cfg_ext > (CFG_W+1)'(FRAMES)) begin
            active_cnt = (SLOT_W+1)'(FRAMES);
        end else begin
            active_cnt = (SLOT_W+1)'(cfg_ext);
        end
    end

    generate
        for (genvar p = 0; p < FRAMES; p++) begin : g_cell
            if (p == 0) begin : g_top
                // The referenced page enters at the most recent position.
                assign d_slot[p]  = chosen_slot;
                assign d_valid[p] = 1'b1;
                assign d_page[p]  = page_in;
            end else begin : g_shift
                assign d_slot[p]  = cell_slot[p-1];
                assign d_valid[p] = cell_valid[p-1];
                assign d_page[p]  = cell_page[p-1];
            end

            assign cell_ctrl[p].clear = in_accept && i_last_reference;
            assign cell_ctrl[p].take  = in_accept && take_vec[p];

            lrupr_cell #(
                .SLOT_W (SLOT_W),
                .PAGE_W (PAGE_W),
                .INDEX  (p)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (cell_ctrl[p]),
                .i_d_slot     (d_slot[p]),
                .i_d_valid    (d_valid[p]),
                .i_d_page     (d_page[p]),
                .i_page       (page_in),
                .i_active_cnt (active_cnt),
                .o_slot       (cell_slot[p]),
                .o_valid      (cell_valid[p]),
                .o_page       (cell_page[p]),
                .o_stat       (cell_stat[p])
            );
        end
    endgenerate

    // Lookup and replacement choice. Hits and empty frames are gathered per
    // slot number so the lowest slot wins; the victim is the deepest active
    // position in the stack.
    always_comb begin
        logic run;
        hit_vec     = '0;
        empty_vec   = '0;
        hit_slot    = '0;
        empty_slot  = '0;
        victim_slot = '0;
        victim_page = '0;
        for (int p = 0; p < FRAMES; p++) begin
            for (int s = 0; s < FRAMES; s++) begin
                if (cell_slot[p] == SLOT_W'(s)) begin
                    hit_vec[s]   = hit_vec[s] | cell_stat[p].hit;
                    empty_vec[s] = empty_vec[s] | cell_stat[p].empty;
                end
            end
            if (cell_stat[p].active) begin
                victim_slot = cell_slot[p];
                victim_page = cell_page[p];
            end
        end
        any_hit   = |hit_vec;
        any_empty = |empty_vec;
        for (int s = FRAMES - 1; s >= 0; s--) begin
            if (hit_vec[s]) begin
                hit_slot = SLOT_W'(s);
            end
            if (empty_vec[s]) begin
                empty_slot = SLOT_W'(s);
            end
        end
        priority if (any_hit) begin
            chosen_slot = hit_slot;
        end else if (any_empty) begin
            chosen_slot = empty_slot;
        end else begin
            chosen_slot = victim_slot;
        end
        // Every position at or above the chosen slot's position moves down
        // by one; the positions below it keep their entries.
        run = 1'b0;
        for (int p = FRAMES - 1; p >= 0; p--) begin
            run         = run | (cell_slot[p] == chosen_slot);
            take_vec[p] = run;
        end
    end

    // Fault total counts misses, holds at its maximum and clears on a last reference.
    always_comb begin
        if (any_hit || (r_fault == FAULT_MAX)) begin
            n_fault = r_fault;
        end else begin
            n_fault = r_fault + FAULT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
        end else if (in_accept) begin
            r_fault <= i_last_reference ? '0 : n_fault;
        end
    end

    // Output register: loaded on every accepted reference, emptied when the
    // result transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_hit       <= any_hit;
            r_slot      <= OUT_SLOT_W'(chosen_slot);
            r_ev_valid  <= !any_hit && !any_empty;
            r_ev_page   <= (!any_hit && !any_empty) ? OUT_PAGE_W'(victim_page) : '0;
            r_fault_out <= n_fault;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_frame_slot    = r_slot;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = r_ev_page;
    assign o_fault_count   = r_fault_out;

endmodule
`default_nettype wire

// ----- src/lrupr_checker.sv -----
// Port-level checks of the page replacement block and their bind.
`default_nettype none
`include "lru_page_replacement_macros.svh"
module lrupr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_hit,
    input wire logic [2:0]  o_frame_slot,
    input wire logic        o_evicted_valid,
    input wire logic [7:0]  o_evicted_page,
    input wire logic [15:0] o_fault_count
);

    // A stalled result stays offered, and its frame slot and fault count stay unchanged.
    `LRUPR_ASSERT_NEXT(a_stall_holds_valid, o_valid && i_stall, o_valid)
    `LRUPR_ASSERT_NEXT(a_stall_holds_data, o_valid && i_stall, $stable(o_frame_slot) && $stable(o_fault_count))
    // A hit never evicts, and no eviction shows a zero page.
    `LRUPR_ASSERT_NOW(a_hit_no_evict, o_valid && o_hit, !o_evicted_valid)
    `LRUPR_ASSERT_NOW(a_no_evict_zero, o_valid && !o_evicted_valid, o_evicted_page == 8'd0)
    // A fault always leaves a nonzero fault count.
    `LRUPR_ASSERT_NOW(a_fault_counted, o_valid && !o_hit, o_fault_count != 16'd0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (.*);
`default_nettype wire
